[rtl/core/m3inv_pkg.sv]
// Shared types, constants and helpers for the 3x3 matrix inverse pipeline.
package m3inv_pkg;

  // Matrix shape and element format
  localparam int N_EL   = 9;
  localparam int EL_W   = 32;

  // Datapath widths that do not depend on the fraction width
  localparam int MAG_W  = 64;  // cofactor magnitude
  localparam int T_W    = 96;  // element times cofactor magnitude
  localparam int DET_W  = 98;  // signed determinant sum
  localparam int DMAG_W = 97;  // determinant magnitude
  localparam int D_W    = 98;  // divisor, twice the determinant magnitude
  localparam int QB     = 33;  // quotient bits kept before saturation

  // Configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_MODE      = 1'b1;

  typedef logic signed [EL_W-1:0] elem_t;
  typedef logic [3:0] idx_t;

  // Element indexes of the two products of each cofactor: a*b - c*d
  localparam idx_t COF_A [N_EL] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam idx_t COF_B [N_EL] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam idx_t COF_C [N_EL] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam idx_t COF_D [N_EL] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

  // Cofactor feeding each result element (transpose)
  localparam idx_t TR_IDX [N_EL] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

  // Diagonal positions of the identity
  localparam logic [N_EL-1:0] DIAG = 9'b100010001;

  // Data carried alongside the division
  typedef struct packed {
    logic [N_EL-1:0][EL_W-1:0] m;
    logic [EL_W-1:0]           det_value;
    logic                      sing;
    logic [N_EL-1:0]           neg;
  } div_side_t;

  // Saturate sign and magnitude to a 32-bit two's complement value;
  // big flags a magnitude at or above 2^33.
  function automatic logic [31:0] sat32(input logic neg, input logic big,
                                        input logic [32:0] mag);
    logic [32:0] nm;
    nm = -mag;
    if (neg) begin
      if (big || mag > 33'h080000000) return 32'h80000000;
      return nm[31:0];
    end
    if (big || mag > 33'h07FFFFFFF) return 32'h7FFFFFFF;
    return mag[31:0];
  endfunction

endpackage

[rtl/core/m3inv_div.sv]
// Nine-lane pipelined restoring divider, one quotient bit per stage.
module m3inv_div
  import m3inv_pkg::*;
#(
  parameter int HW = 65
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [N_EL-1:0][HW-1:0]    in_hi,
  input  logic [N_EL-1:0][QB-1:0]    in_lo,
  input  logic [D_W-1:0]             in_d,
  input  div_side_t                  in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [N_EL-1:0][QB-1:0]    out_q,
  output logic [N_EL-1:0]            out_ovf,
  output div_side_t                  out_side
);

  localparam int CW = (HW > D_W) ? HW : D_W;

  logic [QB:0]   v;
  logic [QB+1:0] ce;

  logic [N_EL-1:0][D_W-1:0] rem_r [QB+1];
  logic [N_EL-1:0][QB-1:0]  lo_r  [QB+1];
  logic [N_EL-1:0][QB-1:0]  q_r   [QB+1];
  logic [N_EL-1:0]          ovf_r [QB+1];
  logic [D_W-1:0]           d_r   [QB+1];
  div_side_t                side_r [QB+1];

  logic [N_EL-1:0][D_W:0]   rem2 [QB+1];
  logic [N_EL-1:0][D_W:0]   rsub [QB+1];
  logic [N_EL-1:0]          ge   [QB+1];
  logic [N_EL-1:0]          ovf0;

  // Stall chain: a stage advances when empty or when the next one moves
  always_comb begin
    ce[QB+1] = out_ready;
    for (int k = QB; k >= 0; k--) begin
      ce[k] = !v[k] || ce[k+1];
    end
  end
  assign in_ready = ce[0];

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ce[0]) v[0] <= in_valid;
      for (int k = 1; k <= QB; k++) begin
        if (ce[k]) v[k] <= v[k-1];
      end
    end
  end

  // Overflow when the high part already reaches the divisor
  always_comb begin
    for (int l = 0; l < N_EL; l++) begin
      ovf0[l] = CW'(in_hi[l]) >= CW'(in_d);
    end
  end

  // Trial subtract for each quotient bit
  always_comb begin
    for (int j = 0; j <= QB; j++) begin
      for (int l = 0; l < N_EL; l++) begin
        rem2[j][l] = '0;
        rsub[j][l] = '0;
        ge[j][l]   = 1'b0;
      end
    end
    for (int j = 1; j <= QB; j++) begin
      for (int l = 0; l < N_EL; l++) begin
        rem2[j][l] = {rem_r[j-1][l], lo_r[j-1][l][QB-j]};
        ge[j][l]   = rem2[j][l] >= {1'b0, d_r[j-1]};
        rsub[j][l] = rem2[j][l] - {1'b0, d_r[j-1]};
      end
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    if (ce[0]) begin
      for (int l = 0; l < N_EL; l++) begin
        rem_r[0][l] <= D_W'(in_hi[l]);
      end
      lo_r[0]   <= in_lo;
      q_r[0]    <= '0;
      ovf_r[0]  <= ovf0;
      d_r[0]    <= in_d;
      side_r[0] <= in_side;
    end
    for (int j = 1; j <= QB; j++) begin
      if (ce[j]) begin
        for (int l = 0; l < N_EL; l++) begin
          rem_r[j][l] <= ge[j][l] ? rsub[j][l][D_W-1:0] : rem2[j][l][D_W-1:0];
          q_r[j][l]   <= {q_r[j-1][l][QB-2:0], ge[j][l]};
        end
        lo_r[j]   <= lo_r[j-1];
        ovf_r[j]  <= ovf_r[j-1];
        d_r[j]    <= d_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = v[QB];
  assign out_q     = q_r[QB];
  assign out_ovf   = ovf_r[QB];
  assign out_side  = side_r[QB];

endmodule

[rtl/core/matrix3_inverse.sv]
// Pipelined 3x3 matrix inverse by adjugate, one matrix per cycle unless stalled.
//
// Input stream s_*: one transaction carries a full 3x3 matrix of signed
// Q(32-FRAC_BITS).FRAC_BITS elements. Output stream m_*: one transaction
// per input with the nine inverse elements and the determinant in tdata
// and the singular flag in tuser. A matrix whose exact determinant
// magnitude is at or below singular_threshold is singular; singular_mode then
// returns the identity (0) or the input unchanged (1). Configuration is written
// through cfg_we/cfg_index/cfg_data by the user only while idle; unenforced.
//
// The pipeline has 9 stages of input load, products, cofactors, determinant
// and numerator setup, 34 stages of the restoring divider (one quotient bit
// per stage, nine lanes side by side) and one output register. A new
// matrix is taken every cycle while nothing stalls. When m_tready is low,
// results stay in place, empty stages keep filling and s_tready drops once
// every stage holds a matrix. Reset empties the pipeline and sets the
// threshold to 1 and the mode to identity.
module matrix3_inverse
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // in_r1c1 .. in_r3c3, 32 bits each
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [319:0] m_tdata,   // out_r1c1 .. out_r3c3, det_value, 32 bits each
  output logic         m_tuser,   // singular
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam int NF  = 9;
  localparam int SH  = 2 * FRAC_BITS;
  localparam int NW0 = MAG_W + SH + 1;
  localparam int NW  = ((NW0 > DMAG_W) ? NW0 : DMAG_W) + 1;
  localparam int HW  = NW - QB;
  localparam logic [EL_W-1:0] ONE = EL_W'(1) << FRAC_BITS;

  // Configuration registers
  logic [30:0] thr_reg;
  logic        mode_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_reg  <= 31'd1;
      mode_reg <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_reg  <= cfg_data;
        CFG_MODE:      mode_reg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front pipeline control
  logic [NF:1]   v_f;
  logic [NF+1:1] ce_f;
  logic          div_in_ready;
  logic          div_out_valid;
  logic          out_ce;

  always_comb begin
    ce_f[NF+1] = div_in_ready;
    for (int k = NF; k >= 1; k--) begin
      ce_f[k] = !v_f[k] || ce_f[k+1];
    end
  end
  assign s_tready = ce_f[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= '0;
    end else begin
      if (ce_f[1]) v_f[1] <= s_tvalid;
      for (int k = 2; k <= NF; k++) begin
        if (ce_f[k]) v_f[k] <= v_f[k-1];
      end
    end
  end

  // Stage payloads
  elem_t m1 [N_EL], m2 [N_EL], m3 [N_EL], m4 [N_EL], m5 [N_EL];
  elem_t m6 [N_EL], m7 [N_EL], m8 [N_EL];
  logic signed [63:0]  p2 [2*N_EL];
  logic signed [64:0]  c3 [N_EL];
  logic [MAG_W-1:0]    magc4 [N_EL], magc5 [N_EL], magc6 [N_EL], magc7 [N_EL];
  logic [MAG_W-1:0]    magc8 [N_EL];
  logic [N_EL-1:0]     cneg4, cneg5, cneg6, cneg7, cneg8;
  logic [31:0]         magm4 [3];
  logic [2:0]          pneg4, pneg5, pneg6;
  logic [63:0]         pl5 [3], ph5 [3];
  logic [T_W-1:0]      t6 [3];
  logic signed [DET_W-1:0] term6 [3];
  logic signed [DET_W-1:0] det7;
  logic                dneg8;
  logic [DMAG_W-1:0]   dmag8;

  logic [N_EL-1:0][HW-1:0] hi9;
  logic [N_EL-1:0][QB-1:0] lo9;
  logic [D_W-1:0]          d9;
  div_side_t               side9;

  // Load the input matrix
  always_ff @(posedge clk) begin
    if (ce_f[1]) begin
      for (int i = 0; i < N_EL; i++) m1[i] <= s_tdata[i*EL_W +: EL_W];
    end
  end

  // Form the eighteen minor products
  always_ff @(posedge clk) begin
    if (ce_f[2]) begin
      for (int k = 0; k < N_EL; k++) begin
        p2[2*k]   <= 64'(m1[COF_A[k]]) * 64'(m1[COF_B[k]]);
        p2[2*k+1] <= 64'(m1[COF_C[k]]) * 64'(m1[COF_D[k]]);
      end
      m2 <= m1;
    end
  end

  // Subtract into cofactors
  always_ff @(posedge clk) begin
    if (ce_f[3]) begin
      for (int k = 0; k < N_EL; k++) c3[k] <= 65'(p2[2*k]) - 65'(p2[2*k+1]);
      m3 <= m2;
    end
  end

  // Split into sign and magnitude
  always_ff @(posedge clk) begin
    if (ce_f[4]) begin
      for (int k = 0; k < N_EL; k++) begin
        magc4[k] <= c3[k][64] ? 64'(-c3[k]) : 64'(c3[k]);
        cneg4[k] <= c3[k][64];
      end
      for (int i = 0; i < 3; i++) begin
        magm4[i] <= m3[i][31] ? 32'(-33'(m3[i])) : 32'(m3[i]);
        pneg4[i] <= m3[i][31] ^ c3[i][64];
      end
      m4 <= m3;
    end
  end

  // Partial products of the first row against its cofactors
  always_ff @(posedge clk) begin
    if (ce_f[5]) begin
      for (int i = 0; i < 3; i++) begin
        pl5[i] <= 64'(magm4[i]) * 64'(magc4[i][31:0]);
        ph5[i] <= 64'(magm4[i]) * 64'(magc4[i][63:32]);
      end
      magc5 <= magc4;
      cneg5 <= cneg4;
      pneg5 <= pneg4;
      m5    <= m4;
    end
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    if (ce_f[6]) begin
      for (int i = 0; i < 3; i++) t6[i] <= T_W'(pl5[i]) + {ph5[i], 32'b0};
      magc6 <= magc5;
      cneg6 <= cneg5;
      pneg6 <= pneg5;
      m6    <= m5;
    end
  end

  // Sum the signed terms into the determinant
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      term6[i] = pneg6[i] ? -$signed({2'b00, t6[i]}) : $signed({2'b00, t6[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (ce_f[7]) begin
      det7  <= term6[0] + term6[1] + term6[2];
      magc7 <= magc6;
      cneg7 <= cneg6;
      m7    <= m6;
    end
  end

  // Determinant sign and magnitude
  always_ff @(posedge clk) begin
    if (ce_f[8]) begin
      dneg8 <= det7[DET_W-1];
      dmag8 <= det7[DET_W-1] ? DMAG_W'(-det7) : DMAG_W'(det7);
      magc8 <= magc7;
      cneg8 <= cneg7;
      m8    <= m7;
    end
  end

  // Round the determinant, test for singular, build the numerators
  logic [DMAG_W-1:0] dround;
  logic [DMAG_W-1:0] lim;
  logic [NW-1:0]     num [N_EL];

  assign dround = dmag8 + (DMAG_W'(1) << (SH - 1));
  assign lim    = DMAG_W'({thr_reg, {SH{1'b0}}});

  always_comb begin
    for (int l = 0; l < N_EL; l++) begin
      num[l] = (NW'(magc8[TR_IDX[l]]) << (SH + 1)) + NW'(dmag8);
    end
  end

  always_ff @(posedge clk) begin
    if (ce_f[9]) begin
      for (int l = 0; l < N_EL; l++) begin
        hi9[l]       <= num[l][NW-1:QB];
        lo9[l]       <= num[l][QB-1:0];
        side9.neg[l] <= cneg8[TR_IDX[l]] ^ dneg8;
        side9.m[l]   <= m8[l];
      end
      d9              <= {dmag8, 1'b0};
      side9.sing      <= dmag8 <= lim;
      side9.det_value <= sat32(dneg8, |dround[DMAG_W-1:SH+QB], dround[SH+QB-1:SH]);
    end
  end

  // Divide the transposed cofactors by the determinant
  logic [N_EL-1:0][QB-1:0] div_q;
  logic [N_EL-1:0]         div_ovf;
  div_side_t               div_side;

  m3inv_div #(
    .HW(HW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_f[NF]),
    .in_ready (div_in_ready),
    .in_hi    (hi9),
    .in_lo    (lo9),
    .in_d     (d9),
    .in_side  (side9),
    .out_valid(div_out_valid),
    .out_ready(out_ce),
    .out_q    (div_q),
    .out_ovf  (div_ovf),
    .out_side (div_side)
  );

  // Saturate and select the result
  logic [N_EL-1:0][EL_W-1:0] res_next;

  always_comb begin
    for (int l = 0; l < N_EL; l++) begin
      if (!div_side.sing) begin
        res_next[l] = sat32(div_side.neg[l], div_ovf[l], div_q[l]);
      end else if (mode_reg) begin
        res_next[l] = div_side.m[l];
      end else begin
        res_next[l] = DIAG[l] ? ONE : '0;
      end
    end
  end

  // Output register
  assign out_ce = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ce) begin
      m_tvalid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ce) begin
      m_tdata <= {div_side.det_value, res_next};
      m_tuser <= div_side.sing;
    end
  end

  // With the output empty every stage can advance, so input is open
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Reset empties the output
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Singular result in identity mode carries 1.0 on the diagonal
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser && !mode_reg) |->
      (m_tdata[31:0] == ONE && m_tdata[159:128] == ONE && m_tdata[287:256] == ONE))
    else $error("singular identity result malformed");

endmodule
